// File: rtl/md4_pkg.sv
// Package with the MD4 constants, round tables and shared types.
`default_nettype none

package md4_pkg;

  localparam logic [31:0] IV_A      = 32'h67452301;
  localparam logic [31:0] IV_B      = 32'hefcdab89;
  localparam logic [31:0] IV_C      = 32'h98badcfe;
  localparam logic [31:0] IV_D      = 32'h10325476;
  localparam logic [31:0] K_ROUND2  = 32'h5a827999;
  localparam logic [31:0] K_ROUND3  = 32'h6ed9eba1;
  localparam logic [7:0]  PAD_MARK  = 8'h80;
  localparam logic [6:0]  LEN_OFFSET = 7'd56;
  localparam logic [6:0]  BLOCK_BYTES = 7'd64;
  localparam logic [3:0]  LEN_WORD_LO = 4'd14;
  localparam logic [3:0]  LEN_WORD_HI = 4'd15;
  localparam logic [5:0]  LAST_ROUND = 6'd47;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_RUN,
    ST_ADD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_PAD1,
    PH_PAD2
  } phase_t;

  // How the block store presents its contents to the compression rounds.
  typedef struct packed {
    logic [6:0] keep;  // bytes below this offset come from the store
    logic       mark;  // the byte at offset keep reads as the pad mark
    logic       len;   // the last two words carry the bit length
  } pad_view_t;

  // Message word used by a given round (0 to 47).
  function automatic logic [3:0] word_sel(input logic [5:0] rnd);
    logic [3:0] j;
    j = rnd[3:0];
    case (rnd[5:4])
      2'd0:    word_sel = j;
      2'd1:    word_sel = {j[1:0], j[3:2]};
      2'd2:    word_sel = {j[0], j[1], j[2], j[3]};
      default: word_sel = 4'd0;
    endcase
  endfunction

  // Left rotation of a given round.
  function automatic logic [4:0] rot_amt(input logic [1:0] grp, input logic [1:0] step);
    logic [4:0] s;
    s = 5'd3;
    case (grp)
      2'd0: begin
        case (step)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      2'd1: begin
        case (step)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (step)
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    rot_amt = s;
  endfunction

endpackage

`default_nettype wire

// File: rtl/md4_blk_buf.sv
// Message block store with a padded read view for the compression rounds.
`default_nettype none

module md4_blk_buf (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [5:0]        waddr,
  input  wire logic [7:0]        wdata,
  input  wire logic [3:0]        raddr,
  input  wire md4_pkg::pad_view_t view,
  input  wire logic [63:0]       len_bits,
  output logic [31:0]            rdata
);
  import md4_pkg::*;

  logic [3:0][7:0] mem [16];
  logic [3:0][7:0] rd_word;
  logic [3:0]      rd_addr;
  logic [3:0][7:0] view_bytes;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[5:2]][waddr[1:0]] <= wdata;
    end
    rd_word <= mem[raddr];
    rd_addr <= raddr;
  end

  // Bytes past the fill point read as the pad mark or as zero, so the
  // padding never has to be written into the store.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if ({1'b0, rd_addr, 2'(k)} < view.keep) begin
        view_bytes[k] = rd_word[k];
      end else if (view.mark && !view.keep[6] && {rd_addr, 2'(k)} == view.keep[5:0]) begin
        view_bytes[k] = PAD_MARK;
      end else begin
        view_bytes[k] = 8'h00;
      end
    end
    if (view.len && rd_addr == LEN_WORD_LO) begin
      rdata = len_bits[31:0];
    end else if (view.len && rd_addr == LEN_WORD_HI) begin
      rdata = len_bits[63:32];
    end else begin
      rdata = view_bytes;
    end
  end

endmodule

`default_nettype wire

// File: rtl/md4_round.sv
// One MD4 round step: boolean function, constant, word add and rotation.
`default_nettype none

module md4_round (
  input  wire logic [5:0]  rnd,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic [31:0] c,
  input  wire logic [31:0] d,
  input  wire logic [31:0] w,
  output logic [31:0]      t
);
  import md4_pkg::*;

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  s;

  always_comb begin
    case (rnd[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = ((b & c) | (b & d) | (c & d)) + K_ROUND2;
      default: f = (b ^ c ^ d) + K_ROUND3;
    endcase
    sum = a + f + w;
    s   = rot_amt(rnd[5:4], rnd[1:0]);
    t   = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

endmodule

`default_nettype wire

// File: rtl/md4_message_digest_top.sv
// Top level of the streaming MD4 hash engine: sequencer, chaining state and handshakes.
`default_nettype none

// Channel   Beat content                        Handshake
// -------   ---------------------------------   --------------------
// input     data_byte, has_byte, last           in_valid / in_ready
// output    digest_low, digest_high (128 bits)  out_valid / out_ready
//
// A beat that neither completes a 64-byte block nor carries last is taken and
// the engine is ready again on the next cycle. A beat that completes a block, or
// that carries last, starts the shared round unit, which runs one MD4 round a
// cycle; one block keeps in_ready low through the load, the 48 rounds and the
// final add. A closing beat runs one block, or two when the length no longer
// fits or the beat itself completes a block, and the done state then moves the
// digest into the output register and raises out_valid. in_ready is low meanwhile.
// Reset restores the initial chaining values and clears the bit count; the
// block store itself is not cleared. A digest waits in its output register
// while out_ready is low, and the engine holds before a further digest until
// the waiting one has been taken.

module md4_message_digest_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  data_byte,
  input  wire logic        has_byte,
  input  wire logic        last,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      digest_low,
  output logic [63:0]      digest_high
);
  import md4_pkg::*;

  state_t      state, state_next;
  phase_t      phase, phase_next;
  logic        fin;
  logic [63:0] bit_count;
  logic [5:0]  rnd;
  logic [31:0] chain [4];
  logic [31:0] wa, wb, wc, wd;

  logic        in_fire;
  logic [5:0]  fill;
  logic        byte_fills_block;
  logic [5:0]  rnd_fetch;
  logic [3:0]  raddr;
  logic [31:0] word;
  logic [31:0] t;
  pad_view_t   view;
  logic        load_out;

  assign in_fire          = in_valid && in_ready;
  assign fill             = bit_count[8:3];
  assign byte_fills_block = has_byte && (fill == 6'd63);

  // Block store: each message byte goes in at the current fill position.
  md4_blk_buf u_buf (
    .clk      (clk),
    .we       (in_fire && has_byte),
    .waddr    (fill),
    .wdata    (data_byte),
    .raddr    (raddr),
    .view     (view),
    .len_bits (bit_count),
    .rdata    (word)
  );

  md4_round u_round (
    .rnd (rnd),
    .a   (wa),
    .b   (wb),
    .c   (wc),
    .d   (wd),
    .w   (word),
    .t   (t)
  );

  // The store read is registered, so the word for the next round is fetched
  // in the cycle before its use.
  always_comb begin
    rnd_fetch = (state == ST_RUN) ? rnd + 6'd1 : 6'd0;
    raddr     = word_sel(rnd_fetch);
  end

  // The padded view of the block that the current phase compresses.
  always_comb begin
    case (phase)
      PH_DATA: view = '{keep: BLOCK_BYTES, mark: 1'b0, len: 1'b0};
      PH_PAD1: view = '{keep: {1'b0, fill}, mark: 1'b1, len: ({1'b0, fill} < LEN_OFFSET)};
      PH_PAD2: view = '{keep: 7'd0, mark: 1'b0, len: 1'b1};
      default: view = '{keep: BLOCK_BYTES, mark: 1'b0, len: 1'b0};
    endcase
  end

  always_comb begin
    state_next = state;
    phase_next = phase;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (byte_fills_block) begin
            state_next = ST_LOAD;
            phase_next = PH_DATA;
          end else if (last) begin
            state_next = ST_LOAD;
            phase_next = PH_PAD1;
          end
        end
      end
      ST_LOAD: begin
        state_next = ST_RUN;
      end
      ST_RUN: begin
        if (rnd == LAST_ROUND) begin
          state_next = ST_ADD;
        end
      end
      ST_ADD: begin
        case (phase)
          PH_DATA: begin
            if (fin) begin
              state_next = ST_LOAD;
              phase_next = PH_PAD1;
            end else begin
              state_next = ST_IDLE;
            end
          end
          PH_PAD1: begin
            if ({1'b0, fill} >= LEN_OFFSET) begin
              state_next = ST_LOAD;
              phase_next = PH_PAD2;
            end else begin
              state_next = ST_DONE;
            end
          end
          default: state_next = ST_DONE;
        endcase
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_DATA;
      fin       <= 1'b0;
      bit_count <= 64'd0;
      rnd       <= 6'd0;
      out_valid <= 1'b0;
      chain[0]  <= IV_A;
      chain[1]  <= IV_B;
      chain[2]  <= IV_C;
      chain[3]  <= IV_D;
    end else begin
      phase <= phase_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_fire) begin
        fin <= last;
        if (has_byte) begin
          bit_count <= bit_count + 64'd8;
        end
      end
      case (state)
        ST_LOAD: rnd <= 6'd0;
        ST_RUN:  rnd <= rnd + 6'd1;
        ST_ADD: begin
          chain[0] <= chain[0] + wa;
          chain[1] <= chain[1] + wb;
          chain[2] <= chain[2] + wc;
          chain[3] <= chain[3] + wd;
        end
        default: ;
      endcase
      if (load_out) begin
        bit_count <= 64'd0;
        chain[0]  <= IV_A;
        chain[1]  <= IV_B;
        chain[2]  <= IV_C;
        chain[3]  <= IV_D;
      end
    end
  end

  // Working variables of the compression and the digest output register.
  always_ff @(posedge clk) begin
    if (state == ST_LOAD) begin
      wa <= chain[0];
      wb <= chain[1];
      wc <= chain[2];
      wd <= chain[3];
    end else if (state == ST_RUN) begin
      wa <= wd;
      wd <= wc;
      wc <= wb;
      wb <= t;
    end
    if (load_out) begin
      digest_low  <= {chain[1], chain[0]};
      digest_high <= {chain[3], chain[2]};
    end
  end

endmodule

`default_nettype wire
